@@ rtl/core/per_source_job_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the per-source job scheduler.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_JOB_SCHEDULER_MACROS_SVH
`define PER_SOURCE_JOB_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSJS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("psjs assertion failed");
`define PSJS_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("psjs assertion failed");
`else
`define PSJS_ASSERT(lbl, clk, rst_n, prop)
`define PSJS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ rtl/core/psjs_pkg.sv @@
// ----------------------------------------------------------------------------
// psjs_pkg
// Shared beat types, operation codes and controller commands of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psjs_pkg;

    // The source and generation fields of the beats match these in width, though they are declared with fixed widths.
    localparam int NUM_SOURCES = 8;
    localparam int GEN_BITS    = 16;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  source;
        logic [15:0] tag;
        logic [15:0] generation;
        logic        holds_reservation;
        logic        release_ai;
    } t_in;

    typedef struct packed {
        logic        granted;
        logic [15:0] out_tag;
        logic [2:0]  out_source;
        logic [15:0] out_generation;
        logic [1:0]  out_class;
        logic        dropped;
        logic        replaced;
        logic [15:0] replaced_tag;
        logic        live_ai_work;
        logic        is_current;
    } t_out;

    localparam logic [3:0] KIND_INGRESS  = 4'd0;
    localparam logic [3:0] KIND_CONT     = 4'd1;
    localparam logic [3:0] KIND_AI       = 4'd2;
    localparam logic [3:0] KIND_POP      = 4'd3;
    localparam logic [3:0] KIND_COMPLETE = 4'd4;
    localparam logic [3:0] KIND_PURGE    = 4'd5;
    localparam logic [3:0] KIND_BG_ACQ   = 4'd6;
    localparam logic [3:0] KIND_BG_DONE  = 4'd7;
    localparam logic [3:0] KIND_CHECK    = 4'd8;

    localparam logic [1:0] CLS_INGRESS = 2'd0;
    localparam logic [1:0] CLS_CONT    = 2'd1;
    localparam logic [1:0] CLS_AI_CAND = 2'd2;
    localparam logic [1:0] CLS_AI_CONT = 2'd3;

    localparam logic       REG_MAX_AI_JOBS = 1'b0;
    localparam logic [7:0] MAX_AI_RESET    = 8'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_EXEC,
        OP_SCAN_INIT,
        OP_ESS_INIT,
        OP_ESS_ADV,
        OP_NEXT,
        OP_DROP,
        OP_TAKE_Q,
        OP_TAKE_ING,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        LST_CONT,
        LST_AIQ,
        LST_CAND
    } t_list;

    typedef struct packed {
        t_op   op;
        t_list lst;
    } t_cmd;

    typedef struct packed {
        logic is_pop;
        logic is_purge;
        logic steps_zero;
        logic src_busy;
        logic ing_valid;
        logic q_end;
        logic match_order;
        logic match_req;
        logic e_stale;
        logic e_busy;
        logic e_has;
        logic ai_full;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/psjs_dpath.sv @@
// ----------------------------------------------------------------------------
// psjs_dpath
// Scheduler state, queues and the per-step operations ordered by the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psjs_dpath #(
    parameter int CONT_DEPTH    = 16,
    parameter int AI_CONT_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psjs_pkg::t_cmd    i_cmd,
    input  psjs_pkg::t_in     i_req,
    input  logic [7:0]        i_max_ai_jobs,
    output psjs_pkg::t_status o_status,
    output psjs_pkg::t_out    o_out_data
);

    localparam int NUM_SOURCES = psjs_pkg::NUM_SOURCES;
    localparam int GEN_BITS    = psjs_pkg::GEN_BITS;
    localparam int SIW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int OCW = $clog2(NUM_SOURCES + 1);
    localparam int CAW = (CONT_DEPTH > 1) ? $clog2(CONT_DEPTH) : 1;
    localparam int CCW = $clog2(CONT_DEPTH + 1);
    localparam int AAW = (AI_CONT_DEPTH > 1) ? $clog2(AI_CONT_DEPTH) : 1;
    localparam int ACW = $clog2(AI_CONT_DEPTH + 1);
    localparam int QW1 = (CCW > ACW) ? CCW : ACW;
    localparam int QW  = (QW1 > OCW) ? QW1 : OCW;
    localparam int CW  = (GEN_BITS > 16) ? GEN_BITS : 16;

    typedef struct packed {
        logic [2:0]          src;
        logic [15:0]         tag;
        logic [GEN_BITS-1:0] gen;
    } t_job;

    psjs_pkg::t_in       r_req;
    psjs_pkg::t_out      r_res;
    psjs_pkg::t_out      r_out;

    logic [2:0]          r_order [NUM_SOURCES];
    logic [OCW-1:0]      r_order_cnt;
    logic [NUM_SOURCES-1:0] r_seen;
    logic [SIW-1:0]      r_rr;
    logic [SIW-1:0]      r_idx;
    logic [OCW-1:0]      r_steps;

    logic [NUM_SOURCES-1:0] r_ing_valid;
    logic [15:0]         r_ing_tag [NUM_SOURCES];
    logic [GEN_BITS-1:0] r_ing_gen [NUM_SOURCES];

    t_job                r_cq [CONT_DEPTH];
    logic [CCW-1:0]      r_cq_cnt;
    t_job                r_cl [NUM_SOURCES];
    logic [OCW-1:0]      r_cl_cnt;
    t_job                r_aq [AI_CONT_DEPTH];
    logic [ACW-1:0]      r_aq_cnt;

    logic [GEN_BITS-1:0] r_gen [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_busy;
    logic [NUM_SOURCES-1:0] r_slot;
    logic [OCW-1:0]      r_slot_cnt;
    logic [7:0]          r_bg;
    logic [QW-1:0]       r_qi;

    logic [SIW-1:0]      req_si;
    logic                req_ok;
    logic [GEN_BITS-1:0] req_cur;
    logic [GEN_BITS-1:0] gen_inc;
    logic [GEN_BITS-1:0] gen_next;
    logic                gen_match;
    logic                push_ok;
    logic [15:0]         push_gen_out;
    logic [1:0]          push_cls;
    t_job                job_new;
    logic [2:0]          ord_src;
    logic [SIW-1:0]      ord_si;
    logic [OCW-1:0]      idx_inc;
    logic [SIW-1:0]      idx_next;
    t_job                ent;
    logic [SIW-1:0]      ent_si;
    logic                q_end;
    logic [1:0]          take_cls;
    logic                cl_hit;
    logic [SIW-1:0]      cl_idx;
    logic                bg_ok;
    logic                live;
    psjs_pkg::t_out      fin_out;

    always_comb begin
        req_si       = SIW'(r_req.source);
        req_ok       = 32'(r_req.source) < 32'(NUM_SOURCES);
        req_cur      = r_gen[req_si];
        gen_inc      = req_cur + GEN_BITS'(1);
        gen_next     = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
        gen_match    = CW'(r_req.generation) == CW'(req_cur);
        push_ok      = req_ok && ((r_req.generation == '0) || gen_match);
        push_gen_out = (req_ok && (r_req.generation == '0)) ? 16'(req_cur)
                                                           : r_req.generation;
        unique case (r_req.kind)
            psjs_pkg::KIND_INGRESS: push_cls = psjs_pkg::CLS_INGRESS;
            psjs_pkg::KIND_CONT:    push_cls = psjs_pkg::CLS_CONT;
            default: push_cls = r_req.holds_reservation ? psjs_pkg::CLS_AI_CONT
                                                        : psjs_pkg::CLS_AI_CAND;
        endcase
        job_new = '{src: r_req.source, tag: r_req.tag, gen: req_cur};

        ord_src  = r_order[r_idx];
        ord_si   = SIW'(ord_src);
        idx_inc  = OCW'(r_idx) + OCW'(1);
        idx_next = (idx_inc == r_order_cnt) ? '0 : SIW'(idx_inc);

        unique case (i_cmd.lst)
            psjs_pkg::LST_CONT: begin
                ent      = r_cq[r_qi[CAW-1:0]];
                q_end    = r_qi >= QW'(r_cq_cnt);
                take_cls = psjs_pkg::CLS_CONT;
            end
            psjs_pkg::LST_AIQ: begin
                ent      = r_aq[r_qi[AAW-1:0]];
                q_end    = r_qi >= QW'(r_aq_cnt);
                take_cls = psjs_pkg::CLS_AI_CONT;
            end
            psjs_pkg::LST_CAND: begin
                ent      = r_cl[r_qi[SIW-1:0]];
                q_end    = r_qi >= QW'(r_cl_cnt);
                take_cls = psjs_pkg::CLS_AI_CAND;
            end
            default: begin
                ent      = '0;
                q_end    = 1'b1;
                take_cls = psjs_pkg::CLS_INGRESS;
            end
        endcase
        ent_si = SIW'(ent.src);

        bg_ok = (r_ing_valid == '0) && (r_cq_cnt == '0) && (r_cl_cnt == '0) &&
                (r_aq_cnt == '0) && (r_busy == '0) && (r_slot == '0) &&
                (r_bg < i_max_ai_jobs);
        live  = (r_cl_cnt != '0) || (r_aq_cnt != '0) || (r_slot != '0);

        fin_out              = r_res;
        fin_out.live_ai_work = live;

        o_status.is_pop      = r_req.kind == psjs_pkg::KIND_POP;
        o_status.is_purge    = r_req.kind == psjs_pkg::KIND_PURGE;
        o_status.steps_zero  = r_steps == '0;
        o_status.src_busy    = r_busy[ord_si];
        o_status.ing_valid   = r_ing_valid[ord_si];
        o_status.q_end       = q_end;
        o_status.match_order = ent.src == ord_src;
        o_status.match_req   = ent.src == r_req.source;
        o_status.e_stale     = ent.gen != r_gen[ent_si];
        o_status.e_busy      = r_busy[ent_si];
        o_status.e_has       = r_slot[ent_si];
        o_status.ai_full     = (9'(r_slot_cnt) + 9'(r_bg)) >= 9'(i_max_ai_jobs);
    end

    // At most one candidate per source, so the first match is the only one.
    always_comb begin
        cl_hit = 1'b0;
        cl_idx = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (!cl_hit && (OCW'(i) < r_cl_cnt) && (r_cl[i].src == r_req.source)) begin
                cl_hit = 1'b1;
                cl_idx = SIW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_cnt <= '0;
            r_seen      <= '0;
            r_rr        <= '0;
            r_idx       <= '0;
            r_steps     <= '0;
            r_ing_valid <= '0;
            r_cq_cnt    <= '0;
            r_cl_cnt    <= '0;
            r_aq_cnt    <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_gen[i] <= GEN_BITS'(1);
            end
            r_busy      <= '0;
            r_slot      <= '0;
            r_slot_cnt  <= '0;
            r_bg        <= '0;
            r_qi        <= '0;
        end else begin
            unique case (i_cmd.op)
                psjs_pkg::OP_NONE: begin
                end
                psjs_pkg::OP_LATCH: begin
                    r_req <= i_req;
                    r_res <= '0;
                end
                psjs_pkg::OP_EXEC: begin
                    r_qi <= '0;
                    unique case (r_req.kind)
                        psjs_pkg::KIND_INGRESS, psjs_pkg::KIND_CONT,
                        psjs_pkg::KIND_AI: begin
                            r_res.out_class      <= push_cls;
                            r_res.out_generation <= push_gen_out;
                            if (!push_ok) begin
                                r_res.dropped <= 1'b1;
                            end else if (r_req.kind == psjs_pkg::KIND_INGRESS) begin
                                if (!r_seen[req_si]) begin
                                    r_seen[req_si] <= 1'b1;
                                    r_order[r_order_cnt[SIW-1:0]] <= r_req.source;
                                    r_order_cnt <= r_order_cnt + 1'b1;
                                end
                                if (r_ing_valid[req_si]) begin
                                    r_res.replaced     <= 1'b1;
                                    r_res.replaced_tag <= r_ing_tag[req_si];
                                end
                                r_ing_valid[req_si] <= 1'b1;
                                r_ing_tag[req_si]   <= r_req.tag;
                                r_ing_gen[req_si]   <= req_cur;
                            end else if (r_req.kind == psjs_pkg::KIND_CONT) begin
                                if (r_cq_cnt >= CCW'(CONT_DEPTH)) begin
                                    r_res.dropped <= 1'b1;
                                end else begin
                                    r_cq[r_cq_cnt[CAW-1:0]] <= job_new;
                                    r_cq_cnt <= r_cq_cnt + 1'b1;
                                    if (!r_seen[req_si]) begin
                                        r_seen[req_si] <= 1'b1;
                                        r_order[r_order_cnt[SIW-1:0]] <= r_req.source;
                                        r_order_cnt <= r_order_cnt + 1'b1;
                                    end
                                end
                            end else if (r_req.holds_reservation) begin
                                if (r_aq_cnt >= ACW'(AI_CONT_DEPTH)) begin
                                    r_res.dropped <= 1'b1;
                                end else begin
                                    r_aq[r_aq_cnt[AAW-1:0]] <= job_new;
                                    r_aq_cnt <= r_aq_cnt + 1'b1;
                                end
                            end else if (cl_hit) begin
                                r_res.replaced     <= 1'b1;
                                r_res.replaced_tag <= r_cl[cl_idx].tag;
                                r_cl[cl_idx]       <= job_new;
                            end else if (r_cl_cnt >= OCW'(NUM_SOURCES)) begin
                                r_res.dropped <= 1'b1;
                            end else begin
                                r_cl[r_cl_cnt[SIW-1:0]] <= job_new;
                                r_cl_cnt <= r_cl_cnt + 1'b1;
                            end
                        end
                        psjs_pkg::KIND_COMPLETE: begin
                            if (req_ok) begin
                                r_busy[req_si] <= 1'b0;
                                if ((r_req.release_ai || !gen_match) && r_slot[req_si]) begin
                                    r_slot[req_si] <= 1'b0;
                                    r_slot_cnt     <= r_slot_cnt - 1'b1;
                                end
                            end
                        end
                        psjs_pkg::KIND_PURGE: begin
                            if (req_ok) begin
                                r_ing_valid[req_si] <= 1'b0;
                                r_gen[req_si]       <= gen_next;
                                if (!r_busy[req_si] && r_slot[req_si]) begin
                                    r_slot[req_si] <= 1'b0;
                                    r_slot_cnt     <= r_slot_cnt - 1'b1;
                                end
                            end
                        end
                        psjs_pkg::KIND_BG_ACQ: begin
                            if (bg_ok) begin
                                r_bg          <= r_bg + 1'b1;
                                r_res.granted <= 1'b1;
                            end
                        end
                        psjs_pkg::KIND_BG_DONE: begin
                            if (r_bg != '0) begin
                                r_bg <= r_bg - 1'b1;
                            end
                        end
                        psjs_pkg::KIND_CHECK: begin
                            if (req_ok) begin
                                r_res.out_generation <= 16'(req_cur);
                                r_res.is_current     <= gen_match;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                psjs_pkg::OP_SCAN_INIT: begin
                    r_qi <= '0;
                end
                psjs_pkg::OP_ESS_INIT: begin
                    r_idx   <= r_rr;
                    r_steps <= r_order_cnt;
                    r_qi    <= '0;
                end
                psjs_pkg::OP_ESS_ADV: begin
                    r_idx   <= idx_next;
                    r_steps <= r_steps - 1'b1;
                    r_qi    <= '0;
                end
                psjs_pkg::OP_NEXT: begin
                    r_qi <= r_qi + 1'b1;
                end
                psjs_pkg::OP_DROP, psjs_pkg::OP_TAKE_Q: begin
                    // Remove the entry under the scan index and close the gap.
                    unique case (i_cmd.lst)
                        psjs_pkg::LST_CONT: begin
                            for (int j = 0; j < CONT_DEPTH - 1; j++) begin
                                if (QW'(j) >= r_qi) begin
                                    r_cq[j] <= r_cq[j + 1];
                                end
                            end
                            r_cq_cnt <= r_cq_cnt - 1'b1;
                        end
                        psjs_pkg::LST_AIQ: begin
                            for (int j = 0; j < AI_CONT_DEPTH - 1; j++) begin
                                if (QW'(j) >= r_qi) begin
                                    r_aq[j] <= r_aq[j + 1];
                                end
                            end
                            r_aq_cnt <= r_aq_cnt - 1'b1;
                        end
                        default: begin
                            for (int j = 0; j < NUM_SOURCES - 1; j++) begin
                                if (QW'(j) >= r_qi) begin
                                    r_cl[j] <= r_cl[j + 1];
                                end
                            end
                            r_cl_cnt <= r_cl_cnt - 1'b1;
                        end
                    endcase
                    if (i_cmd.op == psjs_pkg::OP_TAKE_Q) begin
                        r_busy[ent_si]       <= 1'b1;
                        r_res.granted        <= 1'b1;
                        r_res.out_tag        <= ent.tag;
                        r_res.out_source     <= ent.src;
                        r_res.out_generation <= 16'(ent.gen);
                        r_res.out_class      <= take_cls;
                        if (i_cmd.lst == psjs_pkg::LST_CONT) begin
                            r_rr <= idx_next;
                        end else if (!r_slot[ent_si]) begin
                            r_slot[ent_si] <= 1'b1;
                            r_slot_cnt     <= r_slot_cnt + 1'b1;
                        end
                    end
                end
                psjs_pkg::OP_TAKE_ING: begin
                    r_ing_valid[ord_si]  <= 1'b0;
                    r_busy[ord_si]       <= 1'b1;
                    r_res.granted        <= 1'b1;
                    r_res.out_tag        <= r_ing_tag[ord_si];
                    r_res.out_source     <= ord_src;
                    r_res.out_generation <= 16'(r_ing_gen[ord_si]);
                    r_res.out_class      <= psjs_pkg::CLS_INGRESS;
                    r_rr                 <= idx_next;
                end
                psjs_pkg::OP_FINISH: begin
                    r_out <= fin_out;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

@@ rtl/core/psjs_ctrl.sv @@
// ----------------------------------------------------------------------------
// psjs_ctrl
// Sequencer that walks the datapath through one operation per input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "per_source_job_scheduler_macros.svh"

module psjs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  psjs_pkg::t_status i_status,
    output psjs_pkg::t_cmd    o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ESS_SRC,
        ST_ESS_CQ,
        ST_AIC,
        ST_AIL,
        ST_PG_C,
        ST_PG_A,
        ST_PG_Q,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = psjs_pkg::OP_NONE;
        o_cmd.lst = psjs_pkg::LST_CONT;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = psjs_pkg::OP_LATCH;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_pop) begin
                    o_cmd.op = psjs_pkg::OP_ESS_INIT;
                    n_state  = ST_ESS_SRC;
                end else begin
                    o_cmd.op = psjs_pkg::OP_EXEC;
                    n_state  = i_status.is_purge ? ST_PG_C : ST_FIN;
                end
            end
            ST_ESS_SRC: begin
                if (i_status.steps_zero) begin
                    o_cmd.op = psjs_pkg::OP_SCAN_INIT;
                    n_state  = ST_AIC;
                end else if (i_status.src_busy) begin
                    o_cmd.op = psjs_pkg::OP_ESS_ADV;
                end else begin
                    n_state = ST_ESS_CQ;
                end
            end
            ST_ESS_CQ: begin
                o_cmd.lst = psjs_pkg::LST_CONT;
                priority if (i_status.q_end) begin
                    if (i_status.ing_valid) begin
                        o_cmd.op = psjs_pkg::OP_TAKE_ING;
                        n_state  = ST_FIN;
                    end else begin
                        o_cmd.op = psjs_pkg::OP_ESS_ADV;
                        n_state  = ST_ESS_SRC;
                    end
                end else if (i_status.match_order) begin
                    o_cmd.op = psjs_pkg::OP_TAKE_Q;
                    n_state  = ST_FIN;
                end else begin
                    o_cmd.op = psjs_pkg::OP_NEXT;
                end
            end
            ST_AIC: begin
                o_cmd.lst = psjs_pkg::LST_AIQ;
                priority if (i_status.q_end) begin
                    o_cmd.op = psjs_pkg::OP_SCAN_INIT;
                    n_state  = ST_AIL;
                end else if (i_status.e_stale) begin
                    o_cmd.op = psjs_pkg::OP_DROP;
                end else if (i_status.e_busy) begin
                    o_cmd.op = psjs_pkg::OP_NEXT;
                end else if (!i_status.e_has) begin
                    o_cmd.op = psjs_pkg::OP_DROP;
                end else begin
                    o_cmd.op = psjs_pkg::OP_TAKE_Q;
                    n_state  = ST_FIN;
                end
            end
            ST_AIL: begin
                o_cmd.lst = psjs_pkg::LST_CAND;
                priority if (i_status.q_end) begin
                    n_state = ST_FIN;
                end else if (i_status.e_stale) begin
                    o_cmd.op = psjs_pkg::OP_DROP;
                end else if (i_status.e_busy) begin
                    o_cmd.op = psjs_pkg::OP_NEXT;
                end else if (!i_status.e_has && i_status.ai_full) begin
                    o_cmd.op = psjs_pkg::OP_NEXT;
                end else begin
                    o_cmd.op = psjs_pkg::OP_TAKE_Q;
                    n_state  = ST_FIN;
                end
            end
            ST_PG_C, ST_PG_A, ST_PG_Q: begin
                unique case (r_state)
                    ST_PG_C: o_cmd.lst = psjs_pkg::LST_CONT;
                    ST_PG_A: o_cmd.lst = psjs_pkg::LST_CAND;
                    default: o_cmd.lst = psjs_pkg::LST_AIQ;
                endcase
                priority if (i_status.q_end) begin
                    o_cmd.op = psjs_pkg::OP_SCAN_INIT;
                    unique case (r_state)
                        ST_PG_C: n_state = ST_PG_A;
                        ST_PG_A: n_state = ST_PG_Q;
                        default: n_state = ST_FIN;
                    endcase
                end else if (i_status.match_req) begin
                    o_cmd.op = psjs_pkg::OP_DROP;
                end else begin
                    o_cmd.op = psjs_pkg::OP_NEXT;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = psjs_pkg::OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == psjs_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `PSJS_ASSERT(a_accept_to_exec, i_clk, i_rst_n, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_EXEC))
    `PSJS_ASSERT(a_finish_shows_beat, i_clk, i_rst_n, (o_cmd.op == psjs_pkg::OP_FINISH) |=> r_out_valid)
    `PSJS_ASSERT(a_fin_holds_on_stall, i_clk, i_rst_n, (r_state == ST_FIN && r_out_valid && i_out_stall) |=> (r_state == ST_FIN))
    `PSJS_ASSERT_NORST(a_reset_clears_valid, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

`default_nettype wire

@@ rtl/core/per_source_job_scheduler.sv @@
// ----------------------------------------------------------------------------
// per_source_job_scheduler
// Multi-source job scheduler: coalesced ingress, continuation and AI queues
// served by a round-robin pop, with generation checks and AI slot limits.
//
//   channel  direction  handshake                payload
//   in       sink       i_in_valid / o_in_stall  i_in_data  (psjs_pkg::t_in)
//   out      source     o_out_valid / i_out_stall o_out_data (psjs_pkg::t_out)
//   config   APB slave  psel, penable, pwrite    paddr, pwdata, prdata
//
// Every input beat yields exactly one output beat. Simple operations pass
// through capture, execute and finish steps. A pop visits the sources in
// round-robin order, comparing continuation entries for each idle one,
// then examines the AI continuation and AI candidate entries; a purge
// scans every entry of the three queues. The scans over the queue
// registers are sequential.
// Reset is synchronous; no clearing pass is needed after it.
// A new beat is taken while the previous result still waits on a stalled
// output; the finish step waits only if that result has not left yet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_source_job_scheduler #(
    parameter int CONT_DEPTH    = 16,
    parameter int AI_CONT_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  psjs_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output psjs_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    psjs_pkg::t_cmd    cmd;
    psjs_pkg::t_status status;
    logic [7:0]        r_max_ai_jobs;

    // The AI limit register; a write of zero is stored as one so that at least
    // one AI job may always run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ai_jobs <= psjs_pkg::MAX_AI_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == psjs_pkg::REG_MAX_AI_JOBS)) begin
            r_max_ai_jobs <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psjs_pkg::REG_MAX_AI_JOBS) ? {24'd0, r_max_ai_jobs} : 32'd0;

    // The controller decides each step; the datapath holds the queues and per-source state.
    psjs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    psjs_dpath #(
        .CONT_DEPTH    (CONT_DEPTH),
        .AI_CONT_DEPTH (AI_CONT_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req         (i_in_data),
        .i_max_ai_jobs (r_max_ai_jobs),
        .o_status      (status),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire
